FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/d8sd_pkg.sv
// types, constants and helpers for the d8 steepest descent block
package d8sd_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int COL_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int LINE_AW = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W = 16;
  localparam int HEIGHT_W = 32;
  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int SLOPE_W = 64;
  localparam int EDGE_SHIFT = 31;
  localparam int NUM_NB = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [COL_W-1:0] ROW_LENGTH_RESET = COL_W'(501);
  localparam logic [ROW_W-1:0] ROW_TOTAL_RESET = ROW_W'(501);
  localparam logic [COL_W-1:0] MIN_LENGTH = COL_W'(3);
  localparam logic [ROW_W-1:0] MIN_ROWS = ROW_W'(3);

  // 2^31 / sqrt2 rounded to nearest
  localparam logic signed [31:0] DIAG_SCALE = 32'sd1518500250;

  // register index, taken from the word address
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    DIR_W  = 3'd0,
    DIR_NW = 3'd1,
    DIR_N  = 3'd2,
    DIR_NE = 3'd3,
    DIR_E  = 3'd4,
    DIR_SE = 3'd5,
    DIR_S  = 3'd6,
    DIR_SW = 3'd7
  } dir_t;

  typedef logic [DIFF_W-1:0] diff_t;

  typedef struct packed {
    diff_t [NUM_NB-1:0] diff;
    logic               frame_end;
  } diff_bundle_t;

  typedef struct packed {
    logic [COL_W-1:0] len;
    logic [ROW_W-1:0] rows;
    logic             restart;
  } frame_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } frame_pos_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] val;
    logic [2:0]         idx;
  } cand_t;

  // later candidate wins only on a strictly greater slope
  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = ($signed(b.val) > $signed(a.val)) ? b : a;
  endfunction

endpackage

FILE: rtl/d8_steepest_descent_direction.sv
// d8 steepest descent direction: register port, window and slope selection
// a result follows the input, difference, product, compare and output registers once its window is complete
// throughput: one height sample per cycle unless stalled; each line store takes one read and one write a cycle
// border cells give no result; an output stall reaches the input once all six stages are full
// reset clears control state, window and positions; both registers reset to 501
// line stores are not cleared after reset and fill as the raster streams in
`include "assert_macros.svh"

module d8_steepest_descent_direction import d8sd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                height_valid,
  output logic                height_ready,
  input  logic [HEIGHT_W-1:0] height_sample,
  output logic                flow_valid,
  input  logic                flow_ready,
  output logic [2:0]          flow_direction,
  output logic                frame_end
);

  logic [COL_W-1:0] row_length;
  logic [ROW_W-1:0] row_total;
  logic             cfg_write;
  frame_cfg_t       cfg;
  frame_pos_t       pos;
  logic             diff_valid;
  logic             diff_ready;
  diff_bundle_t     diff_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      row_total  <= ROW_TOTAL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ROW_LENGTH: row_length <= pwdata[COL_W-1:0];
        REG_ROW_TOTAL:  row_total  <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LENGTH: prdata = APB_DW'(row_length);
      REG_ROW_TOTAL:  prdata = APB_DW'(row_total);
      default:        prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (row_length < MIN_LENGTH) begin
      cfg.len = MIN_LENGTH;
    end else if (row_length > COL_W'(MAX_ROW_LENGTH)) begin
      cfg.len = COL_W'(MAX_ROW_LENGTH);
    end else begin
      cfg.len = row_length;
    end
    cfg.rows = (row_total < MIN_ROWS) ? MIN_ROWS : row_total;
    cfg.restart = cfg_write;
  end

  d8sd_window u_window (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .height_valid  (height_valid),
    .height_ready  (height_ready),
    .height_sample (height_sample),
    .diff_valid    (diff_valid),
    .diff_ready    (diff_ready),
    .diff_data     (diff_data),
    .pos           (pos)
  );

  d8sd_slope_select u_slope (
    .clk            (clk),
    .rst            (rst),
    .diff_valid     (diff_valid),
    .diff_ready     (diff_ready),
    .diff_data      (diff_data),
    .flow_valid     (flow_valid),
    .flow_ready     (flow_ready),
    .flow_direction (flow_direction),
    .frame_end      (frame_end)
  );

  `ASSERT_ALWAYS(a_col_in_row, clk, rst, pos.col < cfg.len)
  `ASSERT_ALWAYS(a_row_in_frame, clk, rst, pos.row < cfg.rows)
  `ASSERT_NEXT(a_write_restarts, clk, rst, cfg_write, pos.col == '0 && pos.row == '0)

endmodule

FILE: rtl/d8sd_window.sv
// line stores, position counters, 3x3 window and neighbour differences
module d8sd_window import d8sd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  frame_cfg_t          cfg,
  input  logic                height_valid,
  output logic                height_ready,
  input  logic [HEIGHT_W-1:0] height_sample,
  output logic                diff_valid,
  input  logic                diff_ready,
  output diff_bundle_t        diff_data,
  output frame_pos_t          pos
);

  logic [HEIGHT_W-1:0] older_mem [MAX_ROW_LENGTH];
  logic [HEIGHT_W-1:0] newer_mem [MAX_ROW_LENGTH];
  logic [HEIGHT_W-1:0] older_q;
  logic [HEIGHT_W-1:0] newer_q;
  logic [HEIGHT_W-1:0] win [6];

  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col_inc;
  logic [ROW_W-1:0]    row_inc;

  logic                s1_valid;
  logic [HEIGHT_W-1:0] s1_hin;
  logic [LINE_AW-1:0]  s1_addr;
  logic                s1_emit;
  logic                s1_end;
  logic                s1_adv;
  logic                accept;

  logic [HEIGHT_W-1:0] nb [NUM_NB];
  diff_bundle_t        diff_next;

  assign accept = height_valid && height_ready;
  assign s1_adv = s1_valid && (!s1_emit || !diff_valid || diff_ready);
  assign height_ready = !s1_valid || s1_adv;
  assign col_inc = col + COL_W'(1);
  assign row_inc = row + ROW_W'(1);
  assign pos = '{col: col, row: row};

  // raster position
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= cfg.len) begin
        col <= '0;
        row <= (row_inc >= cfg.rows) ? '0 : row_inc;
      end else begin
        col <= col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (height_ready) begin
      s1_valid <= height_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hin  <= height_sample;
      s1_addr <= col[LINE_AW-1:0];
      s1_emit <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s1_end  <= (row == cfg.rows - ROW_W'(1)) && (col == cfg.len - COL_W'(1));
    end
  end

  // row r-2
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      older_mem[s1_addr] <= newer_q;
    end
    if (accept) begin
      older_q <= older_mem[col[LINE_AW-1:0]];
    end
  end

  // row r-1
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      newer_mem[s1_addr] <= s1_hin;
    end
    if (accept) begin
      newer_q <= newer_mem[col[LINE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[1];
      win[1] <= older_q;
      win[2] <= win[3];
      win[3] <= newer_q;
      win[4] <= win[5];
      win[5] <= s1_hin;
    end
  end

  always_comb begin
    nb[DIR_W]  = win[2];
    nb[DIR_NW] = win[0];
    nb[DIR_N]  = win[1];
    nb[DIR_NE] = older_q;
    nb[DIR_E]  = newer_q;
    nb[DIR_SE] = s1_hin;
    nb[DIR_S]  = win[5];
    nb[DIR_SW] = win[4];
    for (int n = 0; n < NUM_NB; n++) begin
      diff_next.diff[n] = {win[3][HEIGHT_W-1], win[3]} - {nb[n][HEIGHT_W-1], nb[n]};
    end
    diff_next.frame_end = s1_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      diff_valid <= 1'b1;
    end else if (diff_ready) begin
      diff_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      diff_data <= diff_next;
    end
  end

endmodule

FILE: rtl/d8sd_slope_select.sv
// slope products and registered compare tree picking the steepest neighbour
module d8sd_slope_select import d8sd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         diff_valid,
  output logic         diff_ready,
  input  diff_bundle_t diff_data,
  output logic         flow_valid,
  input  logic         flow_ready,
  output logic [2:0]   flow_direction,
  output logic         frame_end
);

  logic               p1_valid;
  cand_t              p1_cand [NUM_NB];
  logic               p1_end;
  logic               p2_valid;
  cand_t              p2_cand [NUM_NB/2];
  logic               p2_end;
  logic               p3_valid;
  cand_t              p3_cand [NUM_NB/4];
  logic               p3_end;

  logic               r1;
  logic               r2;
  logic               r3;
  logic               r4;

  logic signed [SLOPE_W-1:0] d_ext [NUM_NB];
  cand_t              p1_next [NUM_NB];
  cand_t              p4_next;

  assign r4 = !flow_valid || flow_ready;
  assign r3 = !p3_valid || r4;
  assign r2 = !p2_valid || r3;
  assign r1 = !p1_valid || r2;
  assign diff_ready = r1;

  // edge slope is d * 2^31, diagonal slope d * DIAG_SCALE
  always_comb begin
    for (int n = 0; n < NUM_NB; n++) begin
      d_ext[n] = SLOPE_W'($signed(diff_data.diff[n]));
      p1_next[n].idx = 3'(n);
      if (n % 2 == 1) begin
        p1_next[n].val = d_ext[n] * DIAG_SCALE;
      end else begin
        p1_next[n].val = {diff_data.diff[n], {EDGE_SHIFT{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      flow_valid <= 1'b0;
    end else begin
      if (r1) p1_valid <= diff_valid;
      if (r2) p2_valid <= p1_valid;
      if (r3) p3_valid <= p2_valid;
      if (r4) flow_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && diff_valid) begin
      p1_cand <= p1_next;
      p1_end  <= diff_data.frame_end;
    end
    if (r2 && p1_valid) begin
      for (int k = 0; k < NUM_NB/2; k++) begin
        p2_cand[k] <= pick(p1_cand[2*k], p1_cand[2*k+1]);
      end
      p2_end <= p1_end;
    end
    if (r3 && p2_valid) begin
      for (int k = 0; k < NUM_NB/4; k++) begin
        p3_cand[k] <= pick(p2_cand[2*k], p2_cand[2*k+1]);
      end
      p3_end <= p2_end;
    end
    if (r4 && p3_valid) begin
      flow_direction <= p4_next.idx;
      frame_end      <= p3_end;
    end
  end

  assign p4_next = pick(p3_cand[0], p3_cand[1]);

endmodule
